// File: design/cubic_root_scan_bisection_core_assert.svh
// Assertion macros used by the checker file.
`ifndef CUBIC_ROOT_SCAN_BISECTION_CORE_ASSERT_SVH
`define CUBIC_ROOT_SCAN_BISECTION_CORE_ASSERT_SVH
`define CRSB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CRSB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: design/crsb_pkg.sv
//------------------------------------------------------------------------------
// crsb_pkg
// Shared types and constants of the cubic root scan and bisection block.
//------------------------------------------------------------------------------
`default_nettype none
package crsb_pkg;
    localparam int CoefW      = 24;
    localparam int PolyW      = 128;
    localparam int PointW     = 26;
    localparam int RootW      = 24;
    localparam int NearZero   = 33;
    localparam int DefScanLow  = -100;
    localparam int DefScanHigh = 100;
    localparam int DefBisect   = 24;
    localparam int DefMaxRoots = 3;

    typedef struct packed {
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        logic signed [CoefW-1:0] c;
        logic signed [CoefW-1:0] d;
    } t_coefs;

    // Evaluation request to the Horner unit and its reply.
    typedef struct packed {
        logic                     start;
        logic signed [PointW-1:0] x;
    } t_eval_req;

    typedef struct packed {
        logic done;
        logic zero;
        logic neg;
    } t_eval_rsp;
endpackage
`default_nettype wire

// File: design/cubic_root_scan_bisection_core.sv
// Finds up to MAX_ROOTS real roots of a cubic given as four Q11.12 coefficients.
// Each beat is queued, then the back end evaluates the polynomial at every
// integer from SCAN_LOW to SCAN_HIGH and bisects sign changes BISECT_STEPS times.
// Every evaluation runs on the shared 32x26 multiplier and each unit interval adds
// a decision step; the result beats follow and can be held by a stall on the
// output. The next item leaves the queue only once the last beat is issued.
// Roots come out in ascending order as Q7.16; a single beat with root_valid low
// means none.
//------------------------------------------------------------------------------
// cubic_root_scan_bisection_core
// Top level: coefficient queue in front, scan and bisection engine behind.
//------------------------------------------------------------------------------
`default_nettype none
module cubic_root_scan_bisection_core
    import crsb_pkg::*;
#(
    parameter int SCAN_LOW     = DefScanLow,
    parameter int SCAN_HIGH    = DefScanHigh,
    parameter int BISECT_STEPS = DefBisect,
    parameter int MAX_ROOTS    = DefMaxRoots
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic signed [CoefW-1:0] i_coef_cubic,
    input  wire logic signed [CoefW-1:0] i_coef_square,
    input  wire logic signed [CoefW-1:0] i_coef_linear,
    input  wire logic signed [CoefW-1:0] i_coef_constant,
    output logic      o_valid,
    input  wire logic i_ready,
    output logic signed [RootW-1:0] o_root_value,
    output logic      o_root_valid,
    output logic      o_truncated,
    output logic      o_last
);
    t_coefs w_in, w_q;
    logic w_q_valid, w_q_take;

    assign w_in = '{a: i_coef_cubic, b: i_coef_square, c: i_coef_linear,
                    d: i_coef_constant};

    crsb_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_coefs   (w_in),
        .o_q_valid (w_q_valid),
        .i_q_take  (w_q_take),
        .o_q_coefs (w_q)
    );

    crsb_back #(
        .SCAN_LOW(SCAN_LOW), .SCAN_HIGH(SCAN_HIGH),
        .BISECT_STEPS(BISECT_STEPS), .MAX_ROOTS(MAX_ROOTS)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid (w_q_valid),
        .o_q_take  (w_q_take),
        .i_q_coefs (w_q),
        .o_valid, .i_ready, .o_root_value, .o_root_valid, .o_truncated, .o_last
    );
endmodule
`default_nettype wire

// File: design/crsb_horner.sv
//------------------------------------------------------------------------------
// crsb_horner
// Evaluates the sign of the cubic at a Q9.16 point with one shared multiplier,
// by Horner's rule in 128-bit fixed point; the wide product is built up from
// 32-bit partial products, one chunk at a time.
//------------------------------------------------------------------------------
`default_nettype none
module crsb_horner
    import crsb_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_coefs    i_coefs,
    input  wire t_eval_req i_req,
    output t_eval_rsp      o_rsp
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ABS  = 5'b00010,
        S_MUL  = 5'b00100,
        S_ADD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_round, n_round;   // Horner round: 0..2
    logic [1:0] r_part, n_part;     // 32-bit chunk of the accumulator
    logic signed [PolyW-1:0] r_acc, n_acc;
    logic [PolyW-1:0] r_prod, n_prod;
    logic [PointW-1:0] r_mag;
    logic r_xneg;
    logic r_accneg;
    logic [PolyW-1:0] r_accmag;

    logic [31:0] w_chunk;
    logic [63:0] w_pp;
    logic [PolyW-1:0] w_pp_sh;
    logic signed [PolyW-1:0] w_addend;
    logic signed [PolyW-1:0] w_signed_prod;

    always_comb begin
        w_chunk = r_accmag[r_part*32 +: 32];
        w_pp    = {32'd0, w_chunk} * {{(64-PointW){1'b0}}, r_mag};
        w_pp_sh = {64'd0, w_pp} << (r_part * 32);
        unique case (r_round)
            2'd0:    w_addend = PolyW'(signed'(i_coefs.b)) <<< 16;
            2'd1:    w_addend = PolyW'(signed'(i_coefs.c)) <<< 32;
            default: w_addend = PolyW'(signed'(i_coefs.d)) <<< 48;
        endcase
        w_signed_prod = (r_accneg ^ r_xneg) ? -signed'(r_prod) : signed'(r_prod);
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_part  = r_part;
        n_acc   = r_acc;
        n_prod  = r_prod;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) begin
                    n_acc   = PolyW'(signed'(i_coefs.a));
                    n_round = 2'd0;
                    n_part  = 2'd0;
                    n_prod  = '0;
                    n_state = S_ABS;
                end
            end
            // The accumulator's sign and magnitude are latched here.
            S_ABS:   n_state = S_MUL;
            S_MUL: begin
                n_prod = r_prod + w_pp_sh;
                n_part = r_part + 2'd1;
                if (r_part == 2'd3) n_state = S_ADD;
            end
            S_ADD: begin
                n_acc  = w_signed_prod + w_addend;
                n_prod = '0;
                n_part = 2'd0;
                if (r_round == 2'd2) begin
                    n_state = S_DONE;
                end else begin
                    n_round = r_round + 2'd1;
                    n_state = S_ABS;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_round <= n_round;
        r_part  <= n_part;
        r_prod  <= n_prod;
        if (r_state == S_IDLE && i_req.start) begin
            r_xneg <= i_req.x[PointW-1];
            r_mag  <= i_req.x[PointW-1] ? -i_req.x : i_req.x;
        end
        // Magnitude of the accumulator is refreshed before every multiply round.
        if (r_state == S_ABS) begin
            r_accneg <= r_acc[PolyW-1];
            r_accmag <= r_acc[PolyW-1] ? -r_acc : r_acc;
        end
        r_acc <= n_acc;
    end

    assign o_rsp.done = (r_state == S_DONE);
    assign o_rsp.zero = (r_acc == '0);
    assign o_rsp.neg  = r_acc[PolyW-1];
endmodule
`default_nettype wire

// File: design/crsb_front.sv
//------------------------------------------------------------------------------
// crsb_front
// Input side: takes a coefficient beat and holds it in a two-entry queue
// until the back end claims it.
//------------------------------------------------------------------------------
`default_nettype none
module crsb_front
    import crsb_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_coefs i_coefs,
    output logic        o_q_valid,
    input  wire logic   i_q_take,
    output t_coefs      o_q_coefs
);
    t_coefs r_mem [2];
    logic   r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_coefs = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_take && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_coefs;
    end
endmodule
`default_nettype wire

// File: design/crsb_back.sv
//------------------------------------------------------------------------------
// crsb_back
// Scan and bisection sequencer: walks the unit intervals, bisects sign
// changes, and emits roots through an output register.
//------------------------------------------------------------------------------
`default_nettype none
module crsb_back
    import crsb_pkg::*;
#(
    parameter int SCAN_LOW     = DefScanLow,
    parameter int SCAN_HIGH    = DefScanHigh,
    parameter int BISECT_STEPS = DefBisect,
    parameter int MAX_ROOTS    = DefMaxRoots
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    output logic        o_q_take,
    input  wire t_coefs i_q_coefs,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic signed [RootW-1:0] o_root_value,
    output logic        o_root_valid,
    output logic        o_truncated,
    output logic        o_last
);
    localparam int StepW = $clog2(BISECT_STEPS + 1);
    localparam logic signed [PointW-1:0] LowPt  = PointW'(SCAN_LOW * 65536);
    localparam logic signed [PointW-1:0] HighPt = PointW'(SCAN_HIGH * 65536);
    localparam logic signed [PointW-1:0] OnePt  = PointW'(65536);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVL   = 9'b000000010,
        S_EVR   = 9'b000000100,
        S_DECIDE= 9'b000001000,
        S_BIS   = 9'b000010000,
        S_FINAL = 9'b000100000,
        S_EMIT  = 9'b001000000,
        S_WAIT  = 9'b010000000,
        S_WEVAL = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_coefs r_coefs;
    t_eval_req w_req;
    t_eval_rsp w_rsp;
    logic r_req_sent;
    logic signed [PointW-1:0] r_n, r_l, r_r;
    logic r_lzero, r_lneg, r_rzero, r_rneg;
    logic [StepW-1:0] r_step;
    logic signed [PointW-1:0] r_roots [3];
    logic [1:0] r_found;
    logic r_trunc;
    logic [1:0] r_emit;
    logic signed [PointW-1:0] w_mid;
    logic signed [PointW-1:0] w_ev_x;

    assign w_mid = r_l + ((r_r - r_l) >>> 1);

    always_comb begin
        unique case (r_state)
            S_EVL:   w_ev_x = r_n;
            S_EVR:   w_ev_x = r_n + OnePt;
            S_BIS:   w_ev_x = w_mid;
            default: w_ev_x = HighPt;
        endcase
        w_req.x     = w_ev_x;
        w_req.start = !r_req_sent && (r_state == S_EVL || r_state == S_EVR
                      || (r_state == S_BIS && r_step != '0) || r_state == S_FINAL);
    end

    crsb_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coefs (r_coefs),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_q_take = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        logic signed [PointW-1:0] v_root;
        logic v_have;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_req_sent <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_EMIT) o_valid <= 1'b0;
            if (w_req.start) r_req_sent <= 1'b1;
            if (w_rsp.done)  r_req_sent <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_coefs <= i_q_coefs;
                        r_n     <= LowPt;
                        r_found <= 2'd0;
                        r_trunc <= 1'b0;
                        r_state <= S_EVL;
                    end
                end
                S_EVL: if (w_rsp.done) begin
                    r_lzero <= w_rsp.zero;
                    r_lneg  <= w_rsp.neg;
                    r_state <= S_EVR;
                end
                S_EVR: if (w_rsp.done) begin
                    r_rzero <= w_rsp.zero;
                    r_rneg  <= w_rsp.neg;
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    v_have = 1'b0;
                    v_root = r_n;
                    if (r_lzero) begin
                        v_have = 1'b1;
                    end else if (!r_rzero && (r_lneg != r_rneg)) begin
                        r_l     <= r_n;
                        r_r     <= r_n + OnePt;
                        r_step  <= StepW'(BISECT_STEPS);
                        r_state <= S_BIS;
                    end
                    if (v_have) begin
                        if (32'(r_found) < MAX_ROOTS) begin
                            r_roots[r_found] <= v_root;
                            r_found <= r_found + 2'd1;
                        end else r_trunc <= 1'b1;
                    end
                    if (r_lzero || r_rzero || (r_lneg == r_rneg)) begin
                        // Right end becomes next left end.
                        r_lzero <= r_rzero;
                        r_lneg  <= r_rneg;
                        if (r_n + OnePt == HighPt) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_n     <= r_n + OnePt;
                            r_state <= S_EVR;
                        end
                    end
                end
                S_BIS: begin
                    if (r_step == '0) begin
                        if (32'(r_found) < MAX_ROOTS) begin
                            r_roots[r_found] <= w_mid;
                            r_found <= r_found + 2'd1;
                        end else r_trunc <= 1'b1;
                        // Left end of next interval has the sign of this right end.
                        r_lzero <= r_rzero;
                        r_lneg  <= r_rneg;
                        if (r_n + OnePt == HighPt) begin
                            r_state <= S_FINAL;
                        end else begin
                            r_n     <= r_n + OnePt;
                            r_state <= S_EVR;
                        end
                    end else if (w_rsp.done) begin
                        if (w_rsp.zero || (w_rsp.neg != r_lneg)) r_r <= w_mid;
                        else r_l <= w_mid;
                        r_step <= r_step - StepW'(1);
                    end
                end
                S_FINAL: if (w_rsp.done) begin
                    if (w_rsp.zero) begin
                        if (32'(r_found) < MAX_ROOTS) begin
                            r_roots[r_found] <= HighPt;
                            r_found <= r_found + 2'd1;
                        end else r_trunc <= 1'b1;
                    end
                    r_emit  <= 2'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        o_truncated <= r_trunc;
                        if (r_found == 2'd0) begin
                            o_root_value <= '0;
                            o_root_valid <= 1'b0;
                            o_last       <= 1'b1;
                            r_state      <= S_IDLE;
                        end else begin
                            v_root = r_roots[r_emit];
                            o_root_value <= (v_root > -PointW'(NearZero) &&
                                             v_root < PointW'(NearZero))
                                            ? '0 : v_root[RootW-1:0];
                            o_root_valid <= 1'b1;
                            o_last       <= (r_emit + 2'd1 == r_found);
                            r_emit       <= r_emit + 2'd1;
                            if (r_emit + 2'd1 == r_found) r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/crsb_checker.sv
//------------------------------------------------------------------------------
// crsb_checker
// Port-level checks of the root finder, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none
`include "cubic_root_scan_bisection_core_assert.svh"
module crsb_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire logic o_root_valid,
    input wire logic o_truncated,
    input wire logic o_last
);
    // A beat without a root is always the only beat of its item.
    `CRSB_ASSERT_IMPL(a_none_last, i_clk, i_rst_n, o_valid && !o_root_valid, o_last && !o_truncated, "empty result not last")
    // A held beat stays valid and keeps its last flag.
    `CRSB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_last), "beat dropped")
    // Truncation is only reported on real roots.
    `CRSB_ASSERT_IMPL(a_trunc, i_clk, i_rst_n, o_valid && o_truncated, o_root_valid, "truncated without root")
endmodule
bind cubic_root_scan_bisection_core crsb_checker u_crsb_checker (.*);
`default_nettype wire
